// ----- design/timed_event_range_query_core_defines.svh -----
// ----------------------------------------------------------------------------
// Timed event range query: assertion macros
// Shared property forms, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_RANGE_QUERY_CORE_DEFINES_SVH
`define TIMED_EVENT_RANGE_QUERY_CORE_DEFINES_SVH

// same-cycle implication
`define TERQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TERQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/terq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event range query package
// Command codes and the compare unit result type.
// ----------------------------------------------------------------------------
package terq_pkg;

    localparam int CMD_BITS = 2;

    localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic above_key;  // entry time > first key (insert shift test)
        logic in_range;   // entry time inside the sampled window
    } t_cmp_res;

endpackage

// ----- design/terq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module terq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/terq_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time compare unit
// Signed compares of one table entry against the insert key or the window.
// ----------------------------------------------------------------------------
module terq_cmp #(
    parameter int TIME_BITS = 32
) (
    input  logic                        i_forward,
    input  logic signed [TIME_BITS-1:0] i_time,
    input  logic signed [TIME_BITS-1:0] i_key_a,
    input  logic signed [TIME_BITS-1:0] i_key_b,
    output terq_pkg::t_cmp_res          o_res
);

    logic gt_a;
    logic lt_a;
    logic gt_b;
    logic lt_b;

    always_comb begin
        gt_a = (i_time > i_key_a);
        lt_a = (i_time < i_key_a);
        gt_b = (i_time > i_key_b);
        lt_b = (i_time < i_key_b);

        o_res.above_key = gt_a;
        // forward: a <= t < b ; backward: b < t <= a
        o_res.in_range  = i_forward ? (!lt_a && lt_b) : (!gt_a && gt_b);
    end

endmodule

// ----- design/timed_event_range_query_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event range query core
// Time-sorted table of event ids with insert, clear and range sample.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Results come
// out one per cycle on o_res_valid and cannot be held off, so the receiver
// must take every strobe. Add: one result (last=1, full_res=1 if the table
// was full and the point dropped). The insert walks down from the top of the
// table moving one entry up per cycle, and busy stays low when the table is
// full. Sample: one result per matching id, ascending for start<=end over
// [start,end), descending for start>end over (end,start]; the final one
// carries last, and a run with no match gives one result with found=0. A
// sample scans every stored entry, one table read per cycle, and busy stays
// low on an empty table. Clear and the unused code leave busy low and give
// no result. Results lag the deciding cycle by one register stage.
// Throughput is set by the single read port of the table and the one
// compare unit behind it.
// ----------------------------------------------------------------------------
`include "timed_event_range_query_core_defines.svh"

module timed_event_range_query_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_BITS   = 32,
    parameter int EVENT_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [terq_pkg::CMD_BITS-1:0]       i_cmd,
    input  logic signed [TIME_BITS-1:0]         i_point_time,
    input  logic [EVENT_BITS-1:0]               i_event_id,
    input  logic signed [TIME_BITS-1:0]         i_range_start,
    input  logic signed [TIME_BITS-1:0]         i_range_end,
    output logic                                o_res_valid,
    output logic                                o_found,
    output logic [EVENT_BITS-1:0]               o_event_out,
    output logic                                o_last,
    output logic                                o_full_res
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = TIME_BITS + EVENT_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,   // shift entries up until the slot is found
        S_PUT  = 5'b00100,   // write the new point at slot zero
        S_SCAN = 5'b01000,   // walk the table, one entry a cycle
        S_END  = 5'b10000    // emit the held match, if any, with last
    } t_state;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_pos, n_pos;
    logic [CW-1:0]          r_left, n_left;
    logic signed [TIME_BITS-1:0] r_key_a, n_key_a;
    logic signed [TIME_BITS-1:0] r_key_b, n_key_b;
    logic [EVENT_BITS-1:0]  r_ev, n_ev;
    logic                   r_fwd, n_fwd;
    logic                   r_pend_vld, n_pend_vld;
    logic [EVENT_BITS-1:0]  r_pend_ev, n_pend_ev;

    logic                   r_res_valid, n_res_valid;
    logic                   r_found, n_found;
    logic [EVENT_BITS-1:0]  r_event_out, n_event_out;
    logic                   r_last, n_last;
    logic                   r_full_res, n_full_res;

    // table port
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [DW-1:0]          wr_data;
    logic [AW-1:0]          rd_addr;
    logic [DW-1:0]          rd_data;
    logic signed [TIME_BITS-1:0] rd_time;
    logic [EVENT_BITS-1:0]  rd_ev;

    logic                   in_fwd;
    logic [CW-1:0]          count_m1;
    logic [CW-1:0]          pos_m1;
    logic [CW-1:0]          pos_m2;
    logic [CW-1:0]          next_idx;
    terq_pkg::t_cmp_res     cmp;

    terq_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_time = $signed(rd_data[DW-1:EVENT_BITS]);
    assign rd_ev   = rd_data[EVENT_BITS-1:0];

    terq_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .i_forward (r_fwd),
        .i_time    (rd_time),
        .i_key_a   (r_key_a),
        .i_key_b   (r_key_b),
        .o_res     (cmp)
    );

    assign busy     = (r_state != S_IDLE);
    assign in_fwd   = (i_range_start <= i_range_end);
    assign count_m1 = r_count - ONE_C;
    assign pos_m1   = r_pos - ONE_C;
    assign pos_m2   = r_pos - CW'(2);
    assign next_idx = r_fwd ? (r_pos + ONE_C) : pos_m1;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_left      = r_left;
        n_key_a     = r_key_a;
        n_key_b     = r_key_b;
        n_ev        = r_ev;
        n_fwd       = r_fwd;
        n_pend_vld  = r_pend_vld;
        n_pend_ev   = r_pend_ev;

        n_res_valid = 1'b0;
        n_found     = 1'b0;
        n_event_out = '0;
        n_last      = 1'b0;
        n_full_res  = 1'b0;

        wr_en   = 1'b0;
        wr_addr = r_pos[AW-1:0];
        wr_data = {r_key_a, r_ev};
        rd_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                // first read goes out with the command beat
                rd_addr = (i_cmd == terq_pkg::CMD_SAMPLE && in_fwd) ? '0 : count_m1[AW-1:0];
                if (start) begin
                    unique case (i_cmd)
                        terq_pkg::CMD_ADD: begin
                            n_key_a = i_point_time;
                            n_ev    = i_event_id;
                            if (r_count == DEPTH_C) begin
                                n_res_valid = 1'b1;
                                n_last      = 1'b1;
                                n_full_res  = 1'b1;
                            end else if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = S_PUT;
                            end else begin
                                n_pos   = r_count;
                                n_state = S_INS;
                            end
                        end
                        terq_pkg::CMD_SAMPLE: begin
                            n_key_a    = i_range_start;
                            n_key_b    = i_range_end;
                            n_fwd      = in_fwd;
                            n_pend_vld = 1'b0;
                            if (r_count == '0) begin
                                n_res_valid = 1'b1;
                                n_last      = 1'b1;
                            end else begin
                                n_pos   = in_fwd ? '0 : count_m1;
                                n_left  = count_m1;
                                n_state = S_SCAN;
                            end
                        end
                        terq_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_INS: begin
                // rd_data holds entry r_pos-1
                rd_addr = pos_m2[AW-1:0];
                wr_en   = 1'b1;
                if (cmp.above_key) begin
                    wr_data = rd_data;
                    n_pos   = pos_m1;
                    if (r_pos == ONE_C) begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_count     = r_count + ONE_C;
                    n_res_valid = 1'b1;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            S_PUT: begin
                wr_en       = 1'b1;
                n_count     = r_count + ONE_C;
                n_res_valid = 1'b1;
                n_last      = 1'b1;
                n_state     = S_IDLE;
            end

            S_SCAN: begin
                // one match is held back so the final one can carry last
                rd_addr = next_idx[AW-1:0];
                if (cmp.in_range) begin
                    if (r_pend_vld) begin
                        n_res_valid = 1'b1;
                        n_found     = 1'b1;
                        n_event_out = r_pend_ev;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_ev  = rd_ev;
                end
                if (r_left == '0) begin
                    n_state = S_END;
                end else begin
                    n_left = r_left - ONE_C;
                    n_pos  = next_idx;
                end
            end

            S_END: begin
                n_res_valid = 1'b1;
                n_found     = r_pend_vld;
                n_event_out = r_pend_vld ? r_pend_ev : '0;
                n_last      = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend_vld  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend_vld  <= n_pend_vld;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_left      <= n_left;
        r_key_a     <= n_key_a;
        r_key_b     <= n_key_b;
        r_ev        <= n_ev;
        r_fwd       <= n_fwd;
        r_pend_ev   <= n_pend_ev;
        r_found     <= n_found;
        r_event_out <= n_event_out;
        r_last      <= n_last;
        r_full_res  <= n_full_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_found     = r_found;
    assign o_event_out = r_event_out;
    assign o_last      = r_last;
    assign o_full_res  = r_full_res;

    // a result beat always follows a command beat or a busy cycle
    `TERQ_ASSERT_NOW(a_res_after_work, o_res_valid, $past(busy || start), "stray result beat")
    // fill count never passes the table size
    `TERQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= DEPTH_C, "point count overflow")
    // the insert walk never reaches slot zero by shifting
    `TERQ_ASSERT_NOW(a_ins_pos, r_state == S_INS, r_pos != '0, "insert position underflow")
    // a dropped add reports as a bare last beat
    `TERQ_ASSERT_NOW(a_full_shape, o_res_valid && o_full_res, o_last && !o_found,
        "full result malformed")
    // clear empties the table at once
    `TERQ_ASSERT_NEXT(a_clear, start && !busy && i_cmd == terq_pkg::CMD_CLEAR, r_count == '0,
        "clear not applied")

endmodule

// ----- tb/sv/tb_timed_event_range_query_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event range query core testbench
// Walks a directed table of commands and then runs random episodes of add,
// sample, clear and unused-code beats. Each accepted command beat goes
// through a local model of the sorted time table. Every result strobe is
// compared with the oldest predicted result, field by field.
// ----------------------------------------------------------------------------
module tb_timed_event_range_query_core;

    localparam int TABLE_DEPTH = 64;
    localparam int TIME_BITS   = 32;
    localparam int EVENT_BITS  = 8;

    // code 3 has no meaning in the block; it must be swallowed without a result
    localparam logic [terq_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [TIME_BITS-1:0] T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
    localparam logic signed [TIME_BITS-1:0] T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};

    // random beats on top of the directed table, about 230 beats in all
    localparam int RANDOM_ITEMS = 207;
    localparam int TAIL_CYCLES  = TABLE_DEPTH + 8;

    // one command beat as driven on the ports
    typedef struct {
        logic [terq_pkg::CMD_BITS-1:0] cmd;
        logic signed [TIME_BITS-1:0]   ptime;
        logic [EVENT_BITS-1:0]         id;
        logic signed [TIME_BITS-1:0]   rstart;
        logic signed [TIME_BITS-1:0]   rend;
    } t_cmd_beat;

    // one result beat as seen on the ports
    typedef struct {
        logic                   found;
        logic [EVENT_BITS-1:0]  event_out;
        logic                   last;
        logic                   full_res;
    } t_result;

    // directed table row; typed rows carry a result that is read off by eye
    typedef struct {
        t_cmd_beat beat;
        bit        typed;
        t_result   res;
    } t_row;

    localparam t_result RES_ADD_OK = '{found: 1'b0, event_out: '0, last: 1'b1, full_res: 1'b0};
    localparam t_result RES_EMPTY  = '{found: 1'b0, event_out: '0, last: 1'b1, full_res: 1'b0};
    localparam t_result RES_NONE   = '{found: 1'b0, event_out: '0, last: 1'b0, full_res: 1'b0};

    // ------------------------------------------------------------------------
    // DUT ports; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          start         = 1'b0;
    logic                          busy;
    logic [terq_pkg::CMD_BITS-1:0] i_cmd         = terq_pkg::CMD_ADD;
    logic signed [TIME_BITS-1:0]   i_point_time  = '0;
    logic [EVENT_BITS-1:0]         i_event_id    = '0;
    logic signed [TIME_BITS-1:0]   i_range_start = '0;
    logic signed [TIME_BITS-1:0]   i_range_end   = '0;
    logic                          o_res_valid;
    logic                          o_found;
    logic [EVENT_BITS-1:0]         o_event_out;
    logic                          o_last;
    logic                          o_full_res;

    timed_event_range_query_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .EVENT_BITS  (EVENT_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_point_time  (i_point_time),
        .i_event_id    (i_event_id),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_res_valid   (o_res_valid),
        .o_found       (o_found),
        .o_event_out   (o_event_out),
        .o_last        (o_last),
        .o_full_res    (o_full_res)
    );

    // 4 ns period
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Local copy of the sorted time table
    // ------------------------------------------------------------------------
    logic signed [TIME_BITS-1:0] table_times [TABLE_DEPTH];
    logic [EVENT_BITS-1:0]       table_ids   [TABLE_DEPTH];
    int                          table_fill;

    t_result step_results [$];   // results of the beat just modelled
    t_result pending_results [$];  // predicted, not yet seen on the ports
    int      error_count;
    t_row    directed_rows [$];

    // Applies one command to the local table and leaves its results in
    // step_results. Inserts go after equal times; samples walk the table
    // upwards for start<=end, downwards otherwise.
    task automatic model_table_cmd(input t_cmd_beat b);
        int      pos;
        t_result r;
        step_results.delete();
        case (b.cmd)
            terq_pkg::CMD_ADD: begin
                r = RES_ADD_OK;
                if (table_fill >= TABLE_DEPTH) begin
                    r.full_res = 1'b1;
                end else begin
                    pos = table_fill;
                    while (pos > 0 && table_times[pos-1] > b.ptime) begin
                        table_times[pos] = table_times[pos-1];
                        table_ids[pos]   = table_ids[pos-1];
                        pos--;
                    end
                    table_times[pos] = b.ptime;
                    table_ids[pos]   = b.id;
                    table_fill++;
                end
                step_results.push_back(r);
            end
            terq_pkg::CMD_SAMPLE: begin
                r = RES_NONE;
                r.found = 1'b1;
                if (b.rstart <= b.rend) begin
                    for (int i = 0; i < table_fill; i++) begin
                        if (table_times[i] >= b.rstart && table_times[i] < b.rend) begin
                            r.event_out = table_ids[i];
                            step_results.push_back(r);
                        end
                    end
                end else begin
                    for (int i = table_fill - 1; i >= 0; i--) begin
                        if (table_times[i] <= b.rstart && table_times[i] > b.rend) begin
                            r.event_out = table_ids[i];
                            step_results.push_back(r);
                        end
                    end
                end
                if (step_results.size() == 0) begin
                    step_results.push_back(RES_EMPTY);
                end else begin
                    step_results[step_results.size()-1].last = 1'b1;
                end
            end
            terq_pkg::CMD_CLEAR: begin
                table_fill = 0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Result checker: the receiver cannot stall, so every strobe is a beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b id=%0h last=%0b full=%0b",
                                          o_found, o_event_out, o_last, o_full_res));
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found)
                    report_mismatch($sformatf("found %0b, want %0b", o_found, want.found));
                if (o_event_out !== want.event_out)
                    report_mismatch($sformatf("event_out %0h, want %0h",
                                              o_event_out, want.event_out));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
                if (o_full_res !== want.full_res)
                    report_mismatch($sformatf("full_res %0b, want %0b",
                                              o_full_res, want.full_res));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------------
    // Called at a rising edge. start is only lowered when a gap follows, so a
    // back-to-back beat never sees start dropped and raised in one step.
    task automatic issue_beat(input t_cmd_beat b, input int gap, input bit typed,
                              input t_result typed_res);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= b.cmd;
        i_point_time  <= b.ptime;
        i_event_id    <= b.id;
        i_range_start <= b.rstart;
        i_range_end   <= b.rend;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // beat taken at this edge
        model_table_cmd(b);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic add_row(input logic [terq_pkg::CMD_BITS-1:0] cmd,
                           input logic signed [TIME_BITS-1:0] pt,
                           input logic [EVENT_BITS-1:0] id,
                           input logic signed [TIME_BITS-1:0] rs,
                           input logic signed [TIME_BITS-1:0] re,
                           input bit typed, input t_result res);
        t_row row;
        row.beat  = '{cmd: cmd, ptime: pt, id: id, rstart: rs, rend: re};
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    // Mostly short gaps, now and then a long one; none in a no-idle stretch
    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 9);
        if (no_idle || r < 6) return 0;
        if (r < 8)            return $urandom_range(1, 3);
        if (r < 9)            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Times: clustered near zero for equal keys, extremes, stored keys and
    // their neighbours, or anywhere in the 32-bit range
    function automatic logic signed [TIME_BITS-1:0] pick_time();
        logic signed [TIME_BITS-1:0] t;
        case ($urandom_range(0, 11))
            0, 1, 2, 3: t = $signed($urandom_range(0, 16)) - 8;
            4:          t = T_MIN;
            5:          t = T_MAX;
            6, 7: begin
                t = (table_fill > 0) ? table_times[$urandom_range(0, table_fill - 1)] : '0;
                t = t + ($signed($urandom_range(0, 2)) - 1);
            end
            default:    t = $urandom;
        endcase
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_cmd_beat b;
        int        counted;
        int        ep_len;
        int        add_pct;
        int        r;
        bit        no_idle;
        bit        first_episode;

        error_count = 0;
        table_fill  = 0;

        // single synchronous reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: empty table, extremes, equal times, both directions
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, 0, 10, 1'b1, RES_EMPTY);
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, 10, -10, 1'b1, RES_EMPTY);
        add_row(terq_pkg::CMD_ADD, T_MIN, 8'h00, '0, '0, 1'b1, RES_ADD_OK);
        add_row(terq_pkg::CMD_ADD, T_MAX, 8'hFF, '0, '0, 1'b1, RES_ADD_OK);
        add_row(terq_pkg::CMD_ADD, 0, 8'h55, '0, '0, 1'b1, RES_ADD_OK);
        add_row(terq_pkg::CMD_ADD, 0, 8'hAA, '0, '0, 1'b1, RES_ADD_OK);   // after the equal key
        add_row(terq_pkg::CMD_ADD, -1, 8'h0F, '0, '0, 1'b1, RES_ADD_OK);
        add_row(terq_pkg::CMD_ADD, 5, 8'h33, '0, '0, 1'b1, RES_ADD_OK);
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, T_MIN, T_MAX, 1'b0, RES_NONE);  // max excluded
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, T_MAX, T_MIN, 1'b0, RES_NONE);  // min excluded
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, 0, 0, 1'b1, RES_EMPTY);
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, 0, 1, 1'b0, RES_NONE);
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, 0, -1, 1'b0, RES_NONE);
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, T_MAX, T_MAX, 1'b1, RES_EMPTY);
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, T_MIN, T_MIN, 1'b1, RES_EMPTY);
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, -1, 6, 1'b0, RES_NONE);
        add_row(CMD_UNUSED, 1, 8'h77, 2, 3, 1'b0, RES_NONE);
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, T_MAX, T_MAX - 1, 1'b0, RES_NONE);
        add_row(terq_pkg::CMD_CLEAR, '0, '0, '0, '0, 1'b0, RES_NONE);
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, T_MIN, T_MAX, 1'b1, RES_EMPTY);
        add_row(terq_pkg::CMD_ADD, 7, 8'h01, '0, '0, 1'b1, RES_ADD_OK);
        add_row(terq_pkg::CMD_SAMPLE, '0, '0, 7, 8, 1'b0, RES_NONE);
        add_row(terq_pkg::CMD_CLEAR, '0, '0, '0, '0, 1'b0, RES_NONE);

        foreach (directed_rows[i]) begin
            issue_beat(directed_rows[i].beat, pick_gap(1'b0),
                       directed_rows[i].typed, directed_rows[i].res);
        end

        // random part: episodes that start from a cleared table. The first
        // one is add-heavy and long enough to run the table into full.
        counted       = 0;
        first_episode = 1'b1;
        while (counted < RANDOM_ITEMS) begin
            b = '{cmd: terq_pkg::CMD_CLEAR, ptime: $urandom, id: EVENT_BITS'($urandom),
                  rstart: $urandom, rend: $urandom};
            issue_beat(b, pick_gap(1'b0), 1'b0, RES_NONE);
            counted++;
            if (first_episode) begin
                ep_len  = 90;
                add_pct = 95;
            end else begin
                ep_len = $urandom_range(30, 90);
                case ($urandom_range(0, 2))
                    0:       add_pct = 50;
                    1:       add_pct = 80;
                    default: add_pct = 95;
                endcase
            end
            first_episode = 1'b0;
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ep_len && counted < RANDOM_ITEMS; k++) begin
                b.ptime  = pick_time();
                b.id     = EVENT_BITS'($urandom_range(0, (1 << EVENT_BITS) - 1));
                b.rstart = pick_time();
                b.rend   = pick_time();
                r = $urandom_range(0, 99);
                if (r < 3)
                    b.cmd = CMD_UNUSED;          // noise, ignored by the block
                else if (r < 5)
                    b.cmd = terq_pkg::CMD_CLEAR; // empties the table mid-episode
                else if ($urandom_range(0, 99) < add_pct)
                    b.cmd = terq_pkg::CMD_ADD;
                else
                    b.cmd = terq_pkg::CMD_SAMPLE;
                issue_beat(b, pick_gap(no_idle), 1'b0, RES_NONE);
                counted++;
            end
        end
        start <= 1'b0;

        // drain: every predicted result must turn up, then a quiet tail
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_timed_event_range_query_core: clean");
        end else begin
            $display("tb_timed_event_range_query_core: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every sample a full walk
    // of the table, every gap at its longest)
    initial begin
        #1000000;
        $display("tb_timed_event_range_query_core: errors");
        $finish;
    end

endmodule
